// ----- rtl/bxavg_pkg.sv -----
package bxavg_pkg;

    // grid and source geometry
    localparam int GRID_SIZE = 16;
    localparam int GRID_LOG2 = $clog2(GRID_SIZE);
    localparam int MAX_DIM   = 1024;

    // field widths
    localparam int CHAN_W    = 8;
    localparam int CELL_W    = GRID_LOG2;
    localparam int DIM_W     = $clog2(MAX_DIM) + 1;
    localparam int CFG_IDX_W = 1;

    // derived internal widths
    localparam int BLK_W   = DIM_W - GRID_LOG2;          // block size, up to MAX_DIM/GRID_SIZE
    localparam int XB_W    = BLK_W - 1;                  // offset inside a block
    localparam int PX_W    = DIM_W - 1;                  // pixel position
    localparam int POS_W   = GRID_LOG2 + 1;              // block column / band, saturates at grid
    localparam int AREA_W  = 2 * BLK_W;
    localparam int BLK_MAX = MAX_DIM / GRID_SIZE;
    localparam int CLAMP_HI_OUT = 250;
    localparam int CLAMP_LO_OUT = 5;
    localparam int SUM_W   = $clog2(CLAMP_HI_OUT * BLK_MAX * BLK_MAX + 1);
    localparam int NCHAN   = 3;

    localparam logic [DIM_W-1:0] IMG_RESET = DIM_W'(16);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [SUM_W-1:0]  t_sum;

    // full-scale and zero values are pulled in before summing
    function automatic t_chan clamp_chan(input t_chan v);
        t_chan r;
        r = v;
        if (v == {CHAN_W{1'b1}}) r = CHAN_W'(CLAMP_HI_OUT);
        else if (v == '0) r = CHAN_W'(CLAMP_LO_OUT);
        return r;
    endfunction

    // saturate a programmed dimension to the supported range
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < DIM_W'(GRID_SIZE)) r = DIM_W'(GRID_SIZE);
        else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
        return r;
    endfunction

endpackage

// ----- rtl/bxavg_if.sv -----
interface bxavg_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bxavg_pkg::CFG_IDX_W-1:0]     index;
    logic [bxavg_pkg::DIM_W-1:0]         data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface bxavg_pix_if;
    logic                        valid;
    logic                        ready;
    logic [bxavg_pkg::CHAN_W-1:0] red;
    logic [bxavg_pkg::CHAN_W-1:0] green;
    logic [bxavg_pkg::CHAN_W-1:0] blue;
    logic                        frame_start;
    modport source (output valid, red, green, blue, frame_start, input ready);
    modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

interface bxavg_cell_if;
    logic                        valid;
    logic                        ready;
    logic [bxavg_pkg::CHAN_W-1:0] red_avg;
    logic [bxavg_pkg::CHAN_W-1:0] green_avg;
    logic [bxavg_pkg::CHAN_W-1:0] blue_avg;
    logic [bxavg_pkg::CELL_W-1:0] cell_col;
    logic [bxavg_pkg::CELL_W-1:0] cell_row;
    logic                        frame_done;
    modport source (output valid, red_avg, green_avg, blue_avg, cell_col, cell_row,
                    frame_done, input ready);
    modport sink   (input valid, red_avg, green_avg, blue_avg, cell_col, cell_row,
                    frame_done, output ready);
endinterface

// ----- rtl/bxavg_ram.sv -----
module bxavg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/box_average_downscaler.sv -----
// channel  | dir | modport | beat contents
// ---------+-----+---------+-------------------------------------------------
// i_cfg    | in  | sink    | index, data (image_width / image_height)
// i_pix    | in  | sink    | red, green, blue, frame_start
// o_cell   | out | source  | red_avg, green_avg, blue_avg, cell_col, cell_row,
//          |     |         | frame_done
//
// a pixel is accepted with its sum ram read in ST_IDLE, then added and written back in ST_RD
// a pixel that completes a block then runs through ST_DIV in the shared
// bit-serial divider and ST_FIN to hand the cell to the output register
// reset is synchronous, active low; the sum ram needs no clearing pass
// the output register holds a cell while the next pixels are taken in;
// a finished cell waits in the divider only if the output is still full
module box_average_downscaler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bxavg_cfg_if.sink     i_cfg,
    bxavg_pix_if.sink     i_pix,
    bxavg_cell_if.source  o_cell
);

    localparam int RAM_W  = bxavg_pkg::NCHAN * bxavg_pkg::SUM_W;
    localparam int CNT_W  = $clog2(bxavg_pkg::SUM_W);
    localparam int GL     = bxavg_pkg::GRID_LOG2;

    // sequencer codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // configuration
    logic [bxavg_pkg::DIM_W-1:0] r_img_w, r_img_h;
    logic [bxavg_pkg::DIM_W-1:0] eff_w, eff_h;
    logic [bxavg_pkg::BLK_W-1:0] blk_w, blk_h;

    // position counters
    logic [bxavg_pkg::PX_W-1:0]  r_px, r_py, n_px, n_py, cur_px, cur_py;
    logic [bxavg_pkg::XB_W-1:0]  r_xb, r_yb, n_xb, n_yb, cur_xb, cur_yb;
    logic [bxavg_pkg::POS_W-1:0] r_col, r_band, n_col, n_band, cur_col, cur_band;

    logic pix_acc;
    logic active, first, blk_end, px_last, py_last, xb_last, yb_last;

    // per-pixel registers captured at accept
    logic [1:0]                   r_state, n_state;
    logic                         r_active, r_first, r_last, r_done;
    logic [GL-1:0]                r_ccol, r_crow;
    bxavg_pkg::t_chan             r_chan [bxavg_pkg::NCHAN];
    logic [bxavg_pkg::AREA_W-1:0] r_area;

    // sum memory
    logic             ram_we, ram_re;
    logic [RAM_W-1:0] ram_rdata, ram_wdata;
    bxavg_pkg::t_sum  sum_new [bxavg_pkg::NCHAN];

    // divider
    logic [CNT_W-1:0]             r_cnt;
    bxavg_pkg::t_sum              r_q   [bxavg_pkg::NCHAN];
    logic [bxavg_pkg::AREA_W-1:0] r_rem [bxavg_pkg::NCHAN];
    logic [bxavg_pkg::AREA_W:0]   div_sh  [bxavg_pkg::NCHAN];
    logic [bxavg_pkg::AREA_W:0]   div_sub [bxavg_pkg::NCHAN];
    logic                         div_ge  [bxavg_pkg::NCHAN];

    // output register
    logic             r_ov, out_free, out_ld;
    bxavg_pkg::t_chan r_avg [bxavg_pkg::NCHAN];
    logic [GL-1:0]    r_ocol, r_orow;
    logic             r_odone;

    // ---------------- configuration port ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= bxavg_pkg::IMG_RESET;
            r_img_h <= bxavg_pkg::IMG_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bxavg_pkg::REG_IMAGE_WIDTH:  r_img_w <= i_cfg.data;
                bxavg_pkg::REG_IMAGE_HEIGHT: r_img_h <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign eff_w = bxavg_pkg::eff_dim(r_img_w);
    assign eff_h = bxavg_pkg::eff_dim(r_img_h);
    // block size is the saturated dimension over the grid, never below one
    assign blk_w = eff_w[bxavg_pkg::DIM_W-1:GL];
    assign blk_h = eff_h[bxavg_pkg::DIM_W-1:GL];

    // ---------------- accept and position tracking ----------------
    assign i_pix.ready = (r_state == ST_IDLE);
    assign pix_acc     = i_pix.valid && i_pix.ready;

    // frame_start restarts the counters before this pixel is placed
    assign cur_px   = i_pix.frame_start ? '0 : r_px;
    assign cur_py   = i_pix.frame_start ? '0 : r_py;
    assign cur_xb   = i_pix.frame_start ? '0 : r_xb;
    assign cur_yb   = i_pix.frame_start ? '0 : r_yb;
    assign cur_col  = i_pix.frame_start ? '0 : r_col;
    assign cur_band = i_pix.frame_start ? '0 : r_band;

    assign active  = (cur_col < bxavg_pkg::POS_W'(bxavg_pkg::GRID_SIZE)) &&
                     (cur_band < bxavg_pkg::POS_W'(bxavg_pkg::GRID_SIZE));
    assign first   = (cur_xb == '0) && (cur_yb == '0);
    assign xb_last = (bxavg_pkg::BLK_W'(cur_xb) + bxavg_pkg::BLK_W'(1)) >= blk_w;
    assign yb_last = (bxavg_pkg::BLK_W'(cur_yb) + bxavg_pkg::BLK_W'(1)) >= blk_h;
    assign blk_end = xb_last && yb_last;
    assign px_last = (bxavg_pkg::DIM_W'(cur_px) + bxavg_pkg::DIM_W'(1)) >= eff_w;
    assign py_last = (bxavg_pkg::DIM_W'(cur_py) + bxavg_pkg::DIM_W'(1)) >= eff_h;

    always_comb begin
        n_px   = r_px;
        n_py   = r_py;
        n_xb   = r_xb;
        n_yb   = r_yb;
        n_col  = r_col;
        n_band = r_band;
        if (pix_acc) begin
            n_py   = cur_py;
            n_yb   = cur_yb;
            n_band = cur_band;
            n_col  = cur_col;
            if (px_last) begin
                // end of row
                n_px  = '0;
                n_xb  = '0;
                n_col = '0;
                if (py_last) begin
                    // end of frame: everything back to the origin
                    n_py   = '0;
                    n_yb   = '0;
                    n_band = '0;
                end else begin
                    n_py = cur_py + 1'b1;
                    if (yb_last) begin
                        n_yb = '0;
                        if (cur_band < bxavg_pkg::POS_W'(bxavg_pkg::GRID_SIZE)) begin
                            n_band = cur_band + 1'b1;
                        end
                    end else begin
                        n_yb = cur_yb + 1'b1;
                    end
                end
            end else begin
                n_px = cur_px + 1'b1;
                if (xb_last) begin
                    n_xb = '0;
                    if (cur_col < bxavg_pkg::POS_W'(bxavg_pkg::GRID_SIZE)) begin
                        n_col = cur_col + 1'b1;
                    end
                end else begin
                    n_xb = cur_xb + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px   <= '0;
            r_py   <= '0;
            r_xb   <= '0;
            r_yb   <= '0;
            r_col  <= '0;
            r_band <= '0;
        end else begin
            r_px   <= n_px;
            r_py   <= n_py;
            r_xb   <= n_xb;
            r_yb   <= n_yb;
            r_col  <= n_col;
            r_band <= n_band;
        end
    end

    // pixel context carried to the read-modify-write cycle
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_active <= active;
            r_first  <= first;
            r_last   <= blk_end;
            r_ccol   <= cur_col[GL-1:0];
            r_crow   <= cur_band[GL-1:0];
            r_done   <= (cur_col == bxavg_pkg::POS_W'(bxavg_pkg::GRID_SIZE - 1)) &&
                        (cur_band == bxavg_pkg::POS_W'(bxavg_pkg::GRID_SIZE - 1));
            r_chan[0] <= bxavg_pkg::clamp_chan(i_pix.red);
            r_chan[1] <= bxavg_pkg::clamp_chan(i_pix.green);
            r_chan[2] <= bxavg_pkg::clamp_chan(i_pix.blue);
            r_area   <= bxavg_pkg::AREA_W'(blk_w) * bxavg_pkg::AREA_W'(blk_h);
        end
    end

    // ---------------- column sum memory ----------------
    // one entry per block column, all three channel sums side by side;
    // the write of one pixel lands before the next pixel is read
    assign ram_re = pix_acc && active;
    assign ram_we = (r_state == ST_RD) && r_active;

    always_comb begin
        for (int c = 0; c < bxavg_pkg::NCHAN; c++) begin
            sum_new[c] = r_first ? bxavg_pkg::SUM_W'(r_chan[c]) :
                         ram_rdata[c*bxavg_pkg::SUM_W +: bxavg_pkg::SUM_W] +
                         bxavg_pkg::SUM_W'(r_chan[c]);
        end
        ram_wdata = {sum_new[2], sum_new[1], sum_new[0]};
    end

    bxavg_ram #(
        .WIDTH (RAM_W),
        .DEPTH (bxavg_pkg::GRID_SIZE)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ccol),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (cur_col[GL-1:0]),
        .o_rdata (ram_rdata)
    );

    // ---------------- restoring divider, one quotient bit a cycle ----------------
    always_comb begin
        for (int c = 0; c < bxavg_pkg::NCHAN; c++) begin
            div_sh[c]  = {r_rem[c], r_q[c][bxavg_pkg::SUM_W-1]};
            div_ge[c]  = div_sh[c] >= {1'b0, r_area};
            div_sub[c] = div_sh[c] - {1'b0, r_area};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RD) begin
            r_cnt <= '0;
            for (int c = 0; c < bxavg_pkg::NCHAN; c++) begin
                r_q[c]   <= sum_new[c];
                r_rem[c] <= '0;
            end
        end else if (r_state == ST_DIV) begin
            r_cnt <= r_cnt + 1'b1;
            for (int c = 0; c < bxavg_pkg::NCHAN; c++) begin
                r_q[c]   <= {r_q[c][bxavg_pkg::SUM_W-2:0], div_ge[c]};
                r_rem[c] <= div_ge[c] ? div_sub[c][bxavg_pkg::AREA_W-1:0]
                                      : div_sh[c][bxavg_pkg::AREA_W-1:0];
            end
        end
    end

    // ---------------- sequencer ----------------
    assign out_free = !r_ov || o_cell.ready;
    assign out_ld   = (r_state == ST_FIN) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (pix_acc) n_state = ST_RD;
            ST_RD:   n_state = (r_active && r_last) ? ST_DIV : ST_IDLE;
            ST_DIV:  if (r_cnt == CNT_W'(bxavg_pkg::SUM_W - 1)) n_state = ST_FIN;
            ST_FIN:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_ld) r_ov <= 1'b1;
            else if (o_cell.ready) r_ov <= 1'b0;
        end
    end

    // ---------------- output register ----------------
    // averages are the low byte of the quotient
    always_ff @(posedge i_clk) begin
        if (out_ld) begin
            for (int c = 0; c < bxavg_pkg::NCHAN; c++) begin
                r_avg[c] <= r_q[c][bxavg_pkg::CHAN_W-1:0];
            end
            r_ocol  <= r_ccol;
            r_orow  <= r_crow;
            r_odone <= r_done;
        end
    end

    assign o_cell.valid      = r_ov;
    assign o_cell.red_avg    = r_avg[0];
    assign o_cell.green_avg  = r_avg[1];
    assign o_cell.blue_avg   = r_avg[2];
    assign o_cell.cell_col   = r_ocol;
    assign o_cell.cell_row   = r_orow;
    assign o_cell.frame_done = r_odone;

`ifndef SYNTHESIS
    // the read-modify-write cycle always follows an accepted pixel
    a_rd_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |-> $past(pix_acc))
        else $error("rmw cycle without accepted pixel");

    // reads and write-backs of the sum memory never overlap
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("sum memory read during write-back");

    // divider count stays inside the quotient width
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt < CNT_W'(bxavg_pkg::SUM_W)))
        else $error("divider count out of range");

    // the last cell of the grid sits in its bottom right corner
    a_done_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cell.valid && o_cell.frame_done) |->
        ((o_cell.cell_col == GL'(bxavg_pkg::GRID_SIZE - 1)) &&
         (o_cell.cell_row == GL'(bxavg_pkg::GRID_SIZE - 1))))
        else $error("frame_done away from last cell");
`endif

endmodule
